// ===== sv/von_mises_equivalent_stress_top_assert.svh =====
// ----------------------------------------------------------------------------
// Von Mises stress assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef VON_MISES_EQUIVALENT_STRESS_TOP_ASSERT_SVH
`define VON_MISES_EQUIVALENT_STRESS_TOP_ASSERT_SVH

// Same-cycle implication.
`define VMES_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("von Mises stress assertion failed");

// Next-cycle implication.
`define VMES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("von Mises stress assertion failed");

`endif

// ===== sv/vmes_pkg.sv =====
// ----------------------------------------------------------------------------
// Von Mises stress package
// Widths and types shared by the stress pipeline modules.
// ----------------------------------------------------------------------------
package vmes_pkg;

    localparam int STRESS_WIDTH = 24;
    localparam int DIFF_W       = STRESS_WIDTH + 1;
    localparam int DSQ_W        = 2 * STRESS_WIDTH + 1;
    localparam int SSQ_W        = 2 * STRESS_WIDTH - 1;
    localparam int NSUM_W       = DSQ_W + 2;
    localparam int SSUM_W       = SSQ_W + 2;
    localparam int HALF_W       = NSUM_W - 1;
    localparam int SH3_W        = SSUM_W + 2;
    localparam int RAD_W        = ((HALF_W > SH3_W) ? HALF_W : SH3_W) + 1;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int OUT_W        = 25;
    localparam int CMP_W        = (ROOT_W > OUT_W) ? ROOT_W : OUT_W;
    localparam int PREP_STAGES  = 5;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef logic signed [STRESS_WIDTH-1:0] t_stress;
    typedef logic signed [DIFF_W-1:0]       t_diff;
    typedef logic        [RAD_W-1:0]        t_rad;
    typedef logic        [ROOT_W-1:0]       t_root;
    typedef logic        [OUT_W-1:0]        t_result;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

// ===== sv/vmes_prep.sv =====
// ----------------------------------------------------------------------------
// Von Mises radicand pipeline
// Five stages: differences, squares, sums, scaling, and the final radicand.
// ----------------------------------------------------------------------------
module vmes_prep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vmes_pkg::t_pipe_ctl i_ctl,
    input  vmes_pkg::t_stress i_normal_x,
    input  vmes_pkg::t_stress i_normal_y,
    input  vmes_pkg::t_stress i_normal_z,
    input  vmes_pkg::t_stress i_shear_xy,
    input  vmes_pkg::t_stress i_shear_yz,
    input  vmes_pkg::t_stress i_shear_zx,
    output logic             o_valid,
    output vmes_pkg::t_rad   o_rad
);
    import vmes_pkg::*;

    logic [PREP_STAGES-1:0] r_vld;

    t_diff   r_dxy, r_dyz, r_dzx;
    t_stress r_txy, r_tyz, r_tzx;

    logic [DSQ_W-1:0]  r_sq_xy, r_sq_yz, r_sq_zx;
    logic [SSQ_W-1:0]  r_sq_txy, r_sq_tyz, r_sq_tzx;
    logic [NSUM_W-1:0] r_nsum;
    logic [SSUM_W-1:0] r_ssum;
    logic [HALF_W-1:0] r_half;
    logic [SH3_W-1:0]  r_sh3;
    t_rad              r_rad;

    logic signed [2*DIFF_W-1:0]       p_xy, p_yz, p_zx;
    logic signed [2*STRESS_WIDTH-1:0] q_xy, q_yz, q_zx;

    assign p_xy = r_dxy * r_dxy;
    assign p_yz = r_dyz * r_dyz;
    assign p_zx = r_dzx * r_dzx;
    assign q_xy = r_txy * r_txy;
    assign q_yz = r_tyz * r_tyz;
    assign q_zx = r_tzx * r_tzx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[PREP_STAGES-2:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_dxy    <= DIFF_W'(i_normal_x) - DIFF_W'(i_normal_y);
            r_dyz    <= DIFF_W'(i_normal_y) - DIFF_W'(i_normal_z);
            r_dzx    <= DIFF_W'(i_normal_z) - DIFF_W'(i_normal_x);
            r_txy    <= i_shear_xy;
            r_tyz    <= i_shear_yz;
            r_tzx    <= i_shear_zx;

            r_sq_xy  <= p_xy[DSQ_W-1:0];
            r_sq_yz  <= p_yz[DSQ_W-1:0];
            r_sq_zx  <= p_zx[DSQ_W-1:0];
            r_sq_txy <= q_xy[SSQ_W-1:0];
            r_sq_tyz <= q_yz[SSQ_W-1:0];
            r_sq_tzx <= q_zx[SSQ_W-1:0];

            r_nsum   <= NSUM_W'(r_sq_xy) + NSUM_W'(r_sq_yz) + NSUM_W'(r_sq_zx);
            r_ssum   <= SSUM_W'(r_sq_txy) + SSUM_W'(r_sq_tyz) + SSUM_W'(r_sq_tzx);

            r_half   <= r_nsum[NSUM_W-1:1];
            r_sh3    <= SH3_W'(r_ssum) + (SH3_W'(r_ssum) << 1);

            r_rad    <= RAD_W'(r_half) + RAD_W'(r_sh3);
        end
    end

    assign o_valid = r_vld[PREP_STAGES-1];
    assign o_rad   = r_rad;

endmodule

// ===== sv/vmes_sqrt.sv =====
// ----------------------------------------------------------------------------
// Von Mises square root pipeline
// Pipelined floor square root, one root bit per stage, then a saturating
// output register.
// ----------------------------------------------------------------------------
module vmes_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vmes_pkg::t_pipe_ctl i_ctl,
    input  vmes_pkg::t_rad      i_rad,
    output logic                o_valid,
    output vmes_pkg::t_result   o_result
);
    import vmes_pkg::*;

    logic [ROOT_W-1:0] r_vld;
    t_rad              r_rem  [ROOT_W-1];
    t_root             r_root [ROOT_W];
    logic              r_out_valid;
    t_result           r_result;

    logic [CMP_W-1:0]  root_wide;

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            localparam int BI = ROOT_W - 1 - k;
            t_rad  rem_in;
            t_root root_in;
            t_rad  trial;
            logic  take;

            if (k == 0) begin : g_first
                assign rem_in  = i_rad;
                assign root_in = '0;
            end else begin : g_rest
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
            end

            assign trial = (RAD_W'(root_in) << (BI + 1)) | (RAD_W'(1) << (2 * BI));
            assign take  = (rem_in >= trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_ctl.en) begin
                    r_vld[k] <= (k == 0) ? i_ctl.valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_root[k] <= take ? (root_in | (ROOT_W'(1) << BI)) : root_in;
                end
            end

            if (k < ROOT_W - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (i_ctl.en) begin
                        r_rem[k] <= take ? (rem_in - trial) : rem_in;
                    end
                end
            end
        end
    endgenerate

    assign root_wide = CMP_W'(r_root[ROOT_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_out_valid <= r_vld[ROOT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_result <= (root_wide > CMP_W'(OUT_MAX)) ? OUT_MAX : root_wide[OUT_W-1:0];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// ===== sv/von_mises_equivalent_stress_top.sv =====
// ----------------------------------------------------------------------------
// Von Mises equivalent stress
// Streams 3D stress tensors and returns the floor of the von Mises stress.
//
//   Channel  Valid       Ready        Payload
//   input    i_in_valid  o_in_ready   i_normal_x/y/z, i_shear_xy/yz/zx
//   output   o_out_valid i_out_ready  o_equivalent_stress
//
// One item enters per cycle while the output is not stalled; the pipeline has
// five radicand stages, one square root stage per root bit, and one output stage.
// The square root pipeline, one root bit per stage, sets the depth.
// The whole pipeline holds when the output item is not taken, so nothing is
// lost or repeated. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module von_mises_equivalent_stress_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  vmes_pkg::t_stress    i_normal_x,
    input  vmes_pkg::t_stress    i_normal_y,
    input  vmes_pkg::t_stress    i_normal_z,
    input  vmes_pkg::t_stress    i_shear_xy,
    input  vmes_pkg::t_stress    i_shear_yz,
    input  vmes_pkg::t_stress    i_shear_zx,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output vmes_pkg::t_result    o_equivalent_stress
);
    import vmes_pkg::*;

    `include "von_mises_equivalent_stress_top_assert.svh"

    logic      en;
    t_pipe_ctl prep_ctl;
    t_pipe_ctl sqrt_ctl;
    logic      w_rad_valid;
    t_rad      w_rad;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign prep_ctl = '{en: en, valid: i_in_valid};
    assign sqrt_ctl = '{en: en, valid: w_rad_valid};

    vmes_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (prep_ctl),
        .i_normal_x (i_normal_x),
        .i_normal_y (i_normal_y),
        .i_normal_z (i_normal_z),
        .i_shear_xy (i_shear_xy),
        .i_shear_yz (i_shear_yz),
        .i_shear_zx (i_shear_zx),
        .o_valid    (w_rad_valid),
        .o_rad      (w_rad)
    );

    vmes_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (sqrt_ctl),
        .i_rad    (w_rad),
        .o_valid  (o_out_valid),
        .o_result (o_equivalent_stress)
    );

    // A waiting output item freezes the pipeline and blocks new items.
    `VMES_ASSERT_NOW(a_stall_blocks_input, o_out_valid && !i_out_ready, !o_in_ready)
    `VMES_ASSERT_NEXT(a_stall_holds_radicand, o_out_valid && !i_out_ready, $stable(w_rad) && $stable(w_rad_valid))

endmodule
